// ===== hw/rtl/sprf_pkg.sv =====
// Shared types, widths and constants for the sphere pair repulsion force block.
// No dependencies; every other file in hw/rtl imports this package.
package sprf_pkg;

  localparam int COORD_FIELD_W = 32;
  localparam int COORD_WIDTH   = 32;
  localparam int DIFF_W        = COORD_WIDTH + 1;
  localparam int MAG_W         = COORD_WIDTH;
  localparam int SQM_W         = 2 * MAG_W;
  localparam int SQ_W          = SQM_W + 2;
  localparam int ROOT_W        = SQ_W / 2;
  localparam int REM_W         = ROOT_W + 2;
  localparam int RAD_W         = 31;
  localparam int CR_W          = 31;
  localparam int STIFF_W       = 16;
  localparam int THR_W         = RAD_W + 2;
  localparam int CSQ_W         = 2 * CR_W;
  localparam int TDSQ_W        = 2 * THR_W;
  localparam int BASE_W        = TDSQ_W + STIFF_W;
  localparam int PART_W        = 28;
  localparam int NPART         = (BASE_W + PART_W - 1) / PART_W;
  localparam int PROD_W        = PART_W + MAG_W;
  localparam int NUMB_W        = BASE_W + MAG_W;
  localparam int FRAC_W        = 16;
  localparam int NUM_W         = NUMB_W + FRAC_W;
  localparam int DENP_W        = CR_W + ROOT_W;
  localparam int DEN_W         = CSQ_W + ROOT_W;
  localparam int QUO_W         = 48;
  localparam int NUMH_W        = NUM_W - QUO_W;
  localparam int FORCE_W       = 48;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam int SQRT_LAT      = ROOT_W;
  localparam int DIV_LAT       = QUO_W + 1;
  localparam int LATENCY       = 3 + SQRT_LAT + 5 + DIV_LAT + 1;

  localparam logic [CR_W-1:0]    CR_RESET    = CR_W'(65536);
  localparam logic [STIFF_W-1:0] STIFF_RESET = STIFF_W'(10000);

  localparam logic REG_CONTACT_RANGE = 1'b0;
  localparam logic REG_STIFFNESS     = 1'b1;

  localparam logic [FORCE_W-1:0] POS_LIMIT = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] NEG_LIMIT = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_FIELD_W-1:0] first_x;
    logic signed [COORD_FIELD_W-1:0] first_y;
    logic signed [COORD_FIELD_W-1:0] first_z;
    logic [RAD_W-1:0]                first_radius;
    logic signed [COORD_FIELD_W-1:0] second_x;
    logic signed [COORD_FIELD_W-1:0] second_y;
    logic signed [COORD_FIELD_W-1:0] second_z;
    logic [RAD_W-1:0]                second_radius;
  } in_item_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic                      in_contact;
    logic                      coincident;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic [CR_W-1:0]    contact_range;
    logic [STIFF_W-1:0] stiffness;
  } cfg_t;

  // carried alongside the square root
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            sgn;
    logic [THR_W-1:0]      thr;
    logic                  coinc;
  } side_t;

  // flags carried alongside the force arithmetic
  typedef struct packed {
    logic [2:0] sgn;
    logic       contact;
    logic       coinc;
  } post_t;

endpackage

// ===== hw/rtl/sprf_cfg.sv =====
// APB-style register file: contact range and stiffness.
// Depends on sprf_pkg.
module sprf_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sprf_pkg::ADDR_W-1:0]  paddr,
  input  logic [sprf_pkg::DATA_W-1:0]  pwdata,
  output logic [sprf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output sprf_pkg::cfg_t               cfg
);
  import sprf_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        REG_CONTACT_RANGE: cfg_nxt.contact_range = pwdata[CR_W-1:0];
        REG_STIFFNESS:     cfg_nxt.stiffness     = pwdata[STIFF_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.contact_range <= CR_RESET;
      cfg_r.stiffness     <= STIFF_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CONTACT_RANGE: prdata = {{(DATA_W-CR_W){1'b0}}, cfg_r.contact_range};
      REG_STIFFNESS:     prdata = {{(DATA_W-STIFF_W){1'b0}}, cfg_r.stiffness};
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/sprf_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side channel.
// Depends on sprf_pkg.
module sprf_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  logic [sprf_pkg::SQ_W-1:0]   rad_i,
  input  sprf_pkg::side_t             side_i,
  output logic                        valid_o,
  output logic [sprf_pkg::ROOT_W-1:0] root_o,
  output sprf_pkg::side_t             side_o
);
  import sprf_pkg::*;

  logic              vld_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SQ_W-1:0]   rad_r  [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   rad_in;
    side_t             side_in;
    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    // bring in the next two radicand bits, try root*4+1
    assign cand  = {rem_in, rad_in[SQ_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_comb begin
      if (cand >= trial) begin
        rem_nxt  = REM_W'(cand - trial);
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(cand);
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      rad_r[k]  <= {rad_in[SQ_W-3:0], 2'b00};
      side_r[k] <= side_in;
    end
  end

  assign valid_o = vld_r[ROOT_W-1];
  assign root_o  = root_r[ROOT_W-1];
  assign side_o  = side_r[ROOT_W-1];

endmodule

// ===== hw/rtl/sprf_div.sv =====
// Pipelined restoring divider: 48-bit truncated quotient plus an overflow flag.
// Depends on sprf_pkg.
module sprf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  input  logic [sprf_pkg::NUM_W-1:0] num_i,
  input  logic [sprf_pkg::DEN_W-1:0] den_i,
  output logic                       valid_o,
  output logic [sprf_pkg::QUO_W-1:0] quo_o,
  output logic                       over_o
);
  import sprf_pkg::*;

  // first stage: quotient overflows iff the high part already reaches den
  logic             init_vld_r;
  logic [DEN_W-1:0] init_rem_r;
  logic [QUO_W-1:0] init_low_r;
  logic [DEN_W-1:0] init_den_r;
  logic             init_over_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_vld_r <= 1'b0;
    end else begin
      init_vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    init_rem_r  <= {{(DEN_W-NUMH_W){1'b0}}, num_i[NUM_W-1:QUO_W]};
    init_low_r  <= num_i[QUO_W-1:0];
    init_den_r  <= den_i;
    init_over_r <= ({{(DEN_W-NUMH_W){1'b0}}, num_i[NUM_W-1:QUO_W]} >= den_i);
  end

  logic             vld_r  [QUO_W];
  logic [DEN_W-1:0] rem_r  [QUO_W];
  logic [QUO_W-1:0] low_r  [QUO_W];
  logic [QUO_W-1:0] quo_r  [QUO_W];
  logic [DEN_W-1:0] den_r  [QUO_W];
  logic             over_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_st
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic             over_in;
    logic [DEN_W:0]   cand;
    logic [DEN_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in    = init_vld_r;
      assign rem_in  = init_rem_r;
      assign low_in  = init_low_r;
      assign quo_in  = '0;
      assign den_in  = init_den_r;
      assign over_in = init_over_r;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign low_in  = low_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign over_in = over_r[k-1];
    end

    assign cand = {rem_in, low_in[QUO_W-1]};
    assign diff = cand - {1'b0, den_in};
    assign take = (cand >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= take ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
      low_r[k]  <= {low_in[QUO_W-2:0], 1'b0};
      quo_r[k]  <= {quo_in[QUO_W-2:0], take};
      den_r[k]  <= den_in;
      over_r[k] <= over_in;
    end
  end

  assign valid_o = vld_r[QUO_W-1];
  assign quo_o   = quo_r[QUO_W-1];
  assign over_o  = over_r[QUO_W-1];

endmodule

// ===== hw/rtl/sphere_pair_repulsion_force_top.sv =====
// Sphere pair repulsion force: top level with front end, force arithmetic and output.
// Depends on sprf_pkg, sprf_cfg, sprf_sqrt and sprf_div.

// Takes one sphere pair per clock whenever busy is low (busy is high during reset
// and falls in the cycle after reset is released) and returns the force on the
// first sphere, marked by a one-cycle out_valid; results cannot be held off. Most
// stages lie in the 33-stage square root and the three 49-stage dividers (an
// overflow stage, then one quotient bit per stage). Configuration must be written
// over the APB-style port while no pair is in flight; the block does not check it.
module sphere_pair_repulsion_force_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  sprf_pkg::in_item_t          in_data,
  output logic                        out_valid,
  output sprf_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sprf_pkg::ADDR_W-1:0] paddr,
  input  logic [sprf_pkg::DATA_W-1:0] pwdata,
  output logic [sprf_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import sprf_pkg::*;

  cfg_t            cfg;
  logic [CR_W-1:0] cr_eff;

  sprf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a zero range behaves as one lsb
  assign cr_eff = (cfg.contact_range == '0) ? CR_W'(1) : cfg.contact_range;

  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  // stage 1: differences, magnitudes, threshold
  logic [COORD_WIDTH-1:0] f_c [3];
  logic [COORD_WIDTH-1:0] s_c [3];
  side_t                  s1_nxt;
  side_t                  s1_r;
  logic                   s1_vld_r;

  assign f_c[0] = in_data.first_x[COORD_WIDTH-1:0];
  assign f_c[1] = in_data.first_y[COORD_WIDTH-1:0];
  assign f_c[2] = in_data.first_z[COORD_WIDTH-1:0];
  assign s_c[0] = in_data.second_x[COORD_WIDTH-1:0];
  assign s_c[1] = in_data.second_y[COORD_WIDTH-1:0];
  assign s_c[2] = in_data.second_z[COORD_WIDTH-1:0];

  always_comb begin
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] absd;
    s1_nxt = '0;
    for (int a = 0; a < 3; a++) begin
      diff = {f_c[a][COORD_WIDTH-1], f_c[a]} - {s_c[a][COORD_WIDTH-1], s_c[a]};
      absd = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      s1_nxt.mag[a] = absd[MAG_W-1:0];
      s1_nxt.sgn[a] = diff[DIFF_W-1];
    end
    s1_nxt.coinc = (s1_nxt.mag == '0);
    s1_nxt.thr   = {2'b00, in_data.first_radius} + {2'b00, in_data.second_radius}
                 + {2'b00, cr_eff};
  end

  // stage 2: squared magnitudes
  logic [SQM_W-1:0] s2_sqm_r [3];
  side_t            s2_r;
  logic             s2_vld_r;

  // stage 3: sum of squares
  logic [SQ_W-1:0]  s3_sq_r;
  side_t            s3_r;
  logic             s3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start & ~busy_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    for (int a = 0; a < 3; a++) begin
      s2_sqm_r[a] <= SQM_W'(s1_r.mag[a]) * SQM_W'(s1_r.mag[a]);
    end
    s2_r    <= s1_r;
    s3_sq_r <= SQ_W'(s2_sqm_r[0]) + SQ_W'(s2_sqm_r[1]) + SQ_W'(s2_sqm_r[2]);
    s3_r    <= s2_r;
  end

  logic              rt_vld;
  logic [ROOT_W-1:0] rt_d;
  side_t             rt_side;

  sprf_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s3_vld_r),
    .rad_i   (s3_sq_r),
    .side_i  (s3_r),
    .valid_o (rt_vld),
    .root_o  (rt_d),
    .side_o  (rt_side)
  );

  // stage A: contact test and overlap
  logic                  sa_vld_r;
  logic [ROOT_W-1:0]     sa_d_r;
  logic [THR_W-1:0]      sa_td_r;
  logic [2:0][MAG_W-1:0] sa_mag_r;
  post_t                 sa_post_r;

  // stage B: squares of overlap and range
  logic                  sb_vld_r;
  logic [TDSQ_W-1:0]     sb_tdsq_r;
  logic [CSQ_W-1:0]      sb_csq_r;
  logic [ROOT_W-1:0]     sb_d_r;
  logic [2:0][MAG_W-1:0] sb_mag_r;
  post_t                 sb_post_r;

  // stage C: gain and split denominator products
  logic                  sc_vld_r;
  logic [BASE_W-1:0]     sc_base_r;
  logic [DENP_W-1:0]     sc_denlo_r;
  logic [DENP_W-1:0]     sc_denhi_r;
  logic [2:0][MAG_W-1:0] sc_mag_r;
  post_t                 sc_post_r;

  // stage D: denominator sum, numerator partial products
  logic                     sd_vld_r;
  logic [DEN_W-1:0]         sd_den_r;
  logic [PROD_W-1:0]        sd_prod_r [3][NPART];
  post_t                    sd_post_r;
  logic [NPART*PART_W-1:0]  base_ext;

  // stage E: numerators
  logic                  se_vld_r;
  logic [NUMB_W-1:0]     se_num_r [3];
  logic [DEN_W-1:0]      se_den_r;
  post_t                 se_post_r;

  assign base_ext = {{(NPART*PART_W-BASE_W){1'b0}}, sc_base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
      sb_vld_r <= 1'b0;
      sc_vld_r <= 1'b0;
      sd_vld_r <= 1'b0;
      se_vld_r <= 1'b0;
    end else begin
      sa_vld_r <= rt_vld;
      sb_vld_r <= sa_vld_r;
      sc_vld_r <= sb_vld_r;
      sd_vld_r <= sc_vld_r;
      se_vld_r <= sd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [NUMB_W-1:0] acc;
    sa_d_r            <= rt_d;
    sa_td_r           <= rt_side.thr - rt_d;
    sa_mag_r          <= rt_side.mag;
    sa_post_r.sgn     <= rt_side.sgn;
    sa_post_r.coinc   <= rt_side.coinc;
    sa_post_r.contact <= (rt_d < rt_side.thr);

    sb_tdsq_r <= TDSQ_W'(sa_td_r) * TDSQ_W'(sa_td_r);
    sb_csq_r  <= CSQ_W'(cr_eff) * CSQ_W'(cr_eff);
    sb_d_r    <= sa_d_r;
    sb_mag_r  <= sa_mag_r;
    sb_post_r <= sa_post_r;

    sc_base_r  <= BASE_W'(sb_tdsq_r) * BASE_W'(cfg.stiffness);
    sc_denlo_r <= DENP_W'(sb_csq_r[CR_W-1:0]) * DENP_W'(sb_d_r);
    sc_denhi_r <= DENP_W'(sb_csq_r[CSQ_W-1:CR_W]) * DENP_W'(sb_d_r);
    sc_mag_r   <= sb_mag_r;
    sc_post_r  <= sb_post_r;

    sd_den_r <= DEN_W'(sc_denlo_r) + (DEN_W'(sc_denhi_r) << CR_W);
    for (int a = 0; a < 3; a++) begin
      for (int p = 0; p < NPART; p++) begin
        sd_prod_r[a][p] <= PROD_W'(base_ext[p*PART_W +: PART_W]) * PROD_W'(sc_mag_r[a]);
      end
    end
    sd_post_r <= sc_post_r;

    for (int a = 0; a < 3; a++) begin
      acc = '0;
      for (int p = 0; p < NPART; p++) begin
        acc = acc + (NUMB_W'(sd_prod_r[a][p]) << (p * PART_W));
      end
      se_num_r[a] <= acc;
    end
    se_den_r  <= sd_den_r;
    se_post_r <= sd_post_r;
  end

  logic             dv_vld  [3];
  logic [QUO_W-1:0] dv_quo  [3];
  logic             dv_over [3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    sprf_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (se_vld_r),
      .num_i   ({se_num_r[a], {FRAC_W{1'b0}}}),
      .den_i   (se_den_r),
      .valid_o (dv_vld[a]),
      .quo_o   (dv_quo[a]),
      .over_o  (dv_over[a])
    );
  end

  // flags follow the dividers
  post_t dl_r [DIV_LAT];
  always_ff @(posedge clk) begin
    dl_r[0] <= se_post_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      dl_r[k] <= dl_r[k-1];
    end
  end

  // output: sign, saturation, zeroing outside contact or for coincident centres
  out_item_t           out_nxt;
  out_item_t           out_r;
  logic                out_vld_r;
  logic [FORCE_W-1:0]  fval [3];

  always_comb begin
    logic       clip;
    logic       active;
    post_t      pf;
    pf     = dl_r[DIV_LAT-1];
    active = pf.contact & ~pf.coinc;
    out_nxt = '0;
    for (int a = 0; a < 3; a++) begin
      if (pf.sgn[a]) begin
        clip    = dv_over[a] | (dv_quo[a][QUO_W-1] & (|dv_quo[a][QUO_W-2:0]));
        fval[a] = clip ? NEG_LIMIT : (~dv_quo[a] + FORCE_W'(1));
      end else begin
        clip    = dv_over[a] | dv_quo[a][QUO_W-1];
        fval[a] = clip ? POS_LIMIT : dv_quo[a];
      end
      if (!active) begin
        fval[a] = '0;
      end
      out_nxt.saturated = out_nxt.saturated | (active & clip);
    end
    out_nxt.force_x    = fval[0];
    out_nxt.force_y    = fval[1];
    out_nxt.force_z    = fval[2];
    out_nxt.in_contact = pf.contact;
    out_nxt.coincident = pf.coinc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld[0] & dv_vld[1] & dv_vld[2];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/sprf_checker.sv =====
// Port-level checks for the sphere pair repulsion force block, bound to the top.
// Depends on sprf_pkg and sphere_pair_repulsion_force_top.
module sprf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input sprf_pkg::out_item_t         out_data
);
  import sprf_pkg::*;

  // every result comes from an earlier accepted input transfer
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input transfer");

  a_no_contact : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_contact |->
      out_data.force_x == '0 && out_data.force_y == '0 &&
      out_data.force_z == '0 && !out_data.saturated)
    else $error("force outside contact");

  a_coincident : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.coincident |->
      out_data.force_x == '0 && out_data.force_y == '0 &&
      out_data.force_z == '0 && !out_data.saturated)
    else $error("force on coincident centres");

  a_sat_limit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.force_x == POS_LIMIT || out_data.force_x == NEG_LIMIT ||
      out_data.force_y == POS_LIMIT || out_data.force_y == NEG_LIMIT ||
      out_data.force_z == POS_LIMIT || out_data.force_z == NEG_LIMIT)
    else $error("saturation flag without a clipped component");

endmodule

bind sphere_pair_repulsion_force_top sprf_checker u_sprf_checker (.*);

// ===== tb/sv/tb_sphere_pair_repulsion_force_top.sv =====
// Testbench for sphere_pair_repulsion_force_top: directed and random sphere pairs,
// force predicted in wide integer arithmetic and checked by a scoreboard class.
// Depends on sprf_pkg and the RTL of the top level.
`timescale 1ns / 100ps

module tb_sphere_pair_repulsion_force_top;
  import sprf_pkg::*;

  typedef logic [255:0] wide_t;

  localparam logic [ADDR_W-1:0] CR_ADDR    = ADDR_W'(4 * REG_CONTACT_RANGE);
  localparam logic [ADDR_W-1:0] STIFF_ADDR = ADDR_W'(4 * REG_STIFFNESS);
  localparam int IDLE_LIMIT = 5000;
  localparam int N_RANDOM   = 1730;

  class force_scoreboard;
    logic [CR_W-1:0]    range_q;
    logic [STIFF_W-1:0] gain;
    out_item_t          pending[$];
    int errors, n_out, n_contact, n_sat, n_coinc;

    function new();
      range_q = CR_RESET;
      gain    = STIFF_RESET;
    endfunction

    function out_item_t predict_force(in_item_t p);
      out_item_t r;
      logic signed [32:0] dv[3];
      wide_t mag[3], sq, root, cand, c, thr, base, den, num, q;
      logic neg;
      sq = '0;
      r  = '0;
      dv[0] = $signed(p.first_x) - $signed(p.second_x);
      dv[1] = $signed(p.first_y) - $signed(p.second_y);
      dv[2] = $signed(p.first_z) - $signed(p.second_z);
      for (int a = 0; a < 3; a++) begin
        mag[a] = dv[a] < 0 ? wide_t'(-dv[a]) : wide_t'(dv[a]);
        mag[a] = mag[a] & 256'h1_FFFF_FFFF;
        sq = sq + mag[a] * mag[a];
      end
      root = '0;
      for (int b = 49; b >= 0; b--) begin
        cand = root | (wide_t'(1) << b);
        if (cand * cand <= sq) root = cand;
      end
      c   = (range_q == 0) ? wide_t'(1) : wide_t'(range_q);
      thr = wide_t'(p.first_radius) + wide_t'(p.second_radius) + c;
      r.in_contact = root < thr;
      r.coincident = sq == 0;
      if (r.in_contact && !r.coincident) begin
        base = (thr - root) * (thr - root) * (wide_t'(gain) << 16);
        den  = c * c * root;
        for (int a = 0; a < 3; a++) begin
          num = base * mag[a];
          q   = num / den;
          neg = dv[a] < 0;
          if (neg && q > wide_t'(NEG_LIMIT)) begin
            q = wide_t'(NEG_LIMIT);
            r.saturated = 1'b1;
          end else if (!neg && q > wide_t'(POS_LIMIT)) begin
            q = wide_t'(POS_LIMIT);
            r.saturated = 1'b1;
          end
          if (neg) q = -q;
          case (a)
            0: r.force_x = q[FORCE_W-1:0];
            1: r.force_y = q[FORCE_W-1:0];
            default: r.force_z = q[FORCE_W-1:0];
          endcase
        end
      end
      return r;
    endfunction

    function void note_pair(in_item_t p);
      pending = {pending, predict_force(p)};
    endfunction

    function void check_force(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      n_out++;
      n_contact += exp_r.in_contact;
      n_sat     += exp_r.saturated;
      n_coinc   += exp_r.coincident;
      if (got.force_x !== exp_r.force_x)
        $display("%0t: force_x expected %h got %h", $time, exp_r.force_x, got.force_x);
      if (got.force_y !== exp_r.force_y)
        $display("%0t: force_y expected %h got %h", $time, exp_r.force_y, got.force_y);
      if (got.force_z !== exp_r.force_z)
        $display("%0t: force_z expected %h got %h", $time, exp_r.force_z, got.force_z);
      if (got.in_contact !== exp_r.in_contact)
        $display("%0t: in_contact expected %b got %b", $time, exp_r.in_contact,
                 got.in_contact);
      if (got.coincident !== exp_r.coincident)
        $display("%0t: coincident expected %b got %b", $time, exp_r.coincident,
                 got.coincident);
      if (got.saturated !== exp_r.saturated)
        $display("%0t: saturated expected %b got %b", $time, exp_r.saturated,
                 got.saturated);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy, out_valid, pready;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;

  force_scoreboard sb = new();
  int idle_cycles = 0;
  int n_sent = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  sphere_pair_repulsion_force_top u_top (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_pair(in_data);
    if (rst_n && out_valid) sb.check_force(out_data);
    if ((rst_n && start && !busy) || (rst_n && out_valid) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == CR_ADDR) sb.range_q = val[CR_W-1:0];
    else sb.gain = val[STIFF_W-1:0];
  endtask

  task automatic drain();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_cfg(logic [CR_W-1:0] cr, logic [STIFF_W-1:0] k);
    drain();
    cfg_write(CR_ADDR, DATA_W'(cr));
    cfg_write(STIFF_ADDR, DATA_W'(k));
    @(posedge clk);
  endtask

  // holds start until the transfer, then maybe leaves a gap
  task automatic send_pair(in_item_t p);
    in_data <= p;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    if (!quiet && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] small_offset(int k);
    logic [31:0] v;
    v = $urandom_range(0, (1 << k));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic in_item_t random_pair();
    in_item_t p;
    int mode, k, kr;
    mode = $urandom_range(0, 99);
    p.first_x = $urandom;
    p.first_y = $urandom;
    p.first_z = $urandom;
    p.first_radius  = $urandom;
    p.second_radius = $urandom;
    if (mode < 15) begin
      p.second_x = $urandom;
      p.second_y = $urandom;
      p.second_z = $urandom;
    end else if (mode < 20) begin
      p.second_x = p.first_x;
      p.second_y = p.first_y;
      p.second_z = p.first_z;
      p.first_radius  = p.first_radius >> $urandom_range(0, 30);
      p.second_radius = p.second_radius >> $urandom_range(0, 30);
    end else begin
      // nearby centres so the contact test goes both ways
      k  = $urandom_range(0, 30);
      kr = $urandom_range(0, (mode < 30) ? 30 : k + 1);
      p.second_x = p.first_x + small_offset(k);
      p.second_y = p.first_y + small_offset($urandom_range(0, k));
      p.second_z = p.first_z + small_offset($urandom_range(0, k));
      p.first_radius  = $urandom_range(0, (1 << kr) - 1);
      p.second_radius = $urandom_range(0, (1 << kr) - 1);
    end
    return p;
  endfunction

  function automatic in_item_t axis_pair(logic [31:0] dx, logic [30:0] r1, logic [30:0] r2);
    in_item_t p;
    p = '0;
    p.first_x = dx;
    p.first_radius = r1;
    p.second_radius = r2;
    return p;
  endfunction

  initial begin
    in_item_t p;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset configuration first
    send_pair(axis_pair(32'h0001_0000, 31'h0001_0000, 31'h0001_0000));
    send_pair(axis_pair(-32'sh0001_0000, 31'h0001_0000, 31'h0001_0000));
    // exactly at the threshold, then one below it
    send_pair(axis_pair(32'h0003_0000, 31'h0001_0000, 31'h0001_0000));
    send_pair(axis_pair(32'h0002_FFFF, 31'h0001_0000, 31'h0001_0000));
    send_pair(axis_pair(32'h0000_0001, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_pair(axis_pair(-32'sh0000_0001, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_pair(axis_pair(32'h0, 31'h0, 31'h0));
    send_pair(axis_pair(32'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    p = '0;
    p.first_x = 32'h7FFF_FFFF; p.first_y = 32'h7FFF_FFFF; p.first_z = 32'h7FFF_FFFF;
    p.second_x = 32'h8000_0000; p.second_y = 32'h8000_0000; p.second_z = 32'h8000_0000;
    p.first_radius = 31'h7FFF_FFFF; p.second_radius = 31'h7FFF_FFFF;
    send_pair(p);
    send_pair(in_item_t'({p.second_x, p.second_y, p.second_z, p.first_radius,
                          p.first_x, p.first_y, p.first_z, p.second_radius}));
    p = '0;
    p.first_y = 32'h0000_8000; p.second_z = 32'h0000_8000;
    p.first_radius = 31'h0000_4000;
    send_pair(p);
    p.first_x = 32'h8000_0000; p.second_x = 32'h8000_0000; p.first_y = 32'h7FFF_FFFF;
    p.second_y = 32'h7FFF_FFFF; p.first_z = 32'hFFFF_FFFF; p.second_z = 32'hFFFF_FFFF;
    send_pair(p);

    set_cfg(CR_W'(1), STIFF_W'(16'hFFFF));
    send_pair(axis_pair(32'h0000_0001, 31'h0, 31'h0));
    send_pair(axis_pair(32'h0000_0001, 31'h0, 31'h1));
    send_pair(axis_pair(-32'sh0000_0100, 31'h0000_0200, 31'h0));
    set_cfg(CR_W'(0), STIFF_W'(1));
    send_pair(axis_pair(32'h0000_0001, 31'h0, 31'h1));
    send_pair(axis_pair(32'h0000_0002, 31'h0, 31'h0));
    set_cfg(CR_W'(31'h7FFF_FFFF), STIFF_W'(0));
    send_pair(axis_pair(32'h0001_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_pair(axis_pair(32'h0, 31'h1, 31'h1));
    set_cfg(CR_RESET, STIFF_RESET);

    // random phases, each with its own configuration
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_cfg(CR_W'(1), STIFF_W'(16'hFFFF));
        2: set_cfg(CR_W'(31'h7FFF_FFFF), STIFF_W'($urandom_range(0, 65535)));
        3: set_cfg(CR_W'($urandom_range(1, 1 << 20)), STIFF_W'($urandom_range(0, 65535)));
        4: set_cfg(CR_W'(0), STIFF_W'(0));
        5: set_cfg(CR_W'($urandom), STIFF_W'($urandom));
        default: ;
      endcase
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        quiet = (ph == 2);
        send_pair(random_pair());
      end
    end
    quiet = 1'b0;

    drain();
    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d pairs sent over several register settings; %0d in contact, %0d clipped,",
             n_sent, sb.n_contact, sb.n_sat);
    $display("%0d with coincident centres, %0d results checked", sb.n_coinc, sb.n_out);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
